// ----- rtl/string_escape_decoder_unit_defines.svh -----
// ---------------------------------------------------------------------------
// string_escape_decoder_unit_defines
// assertion macros shared by the escape decoder rtl
// ---------------------------------------------------------------------------
`ifndef STRING_ESCAPE_DECODER_UNIT_DEFINES_SVH
`define STRING_ESCAPE_DECODER_UNIT_DEFINES_SVH

// condition must hold at every edge outside reset
`define SED_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent on the next edge
`define SED_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/sed_pkg.sv -----
// ---------------------------------------------------------------------------
// sed_pkg
// types, codes and the hex digit decode of the escape decoder
// ---------------------------------------------------------------------------
package sed_pkg;

   localparam int CHAR_W = 8;
   localparam int ERR_W  = 3;

   typedef enum logic [3:0] {
      MODE_TEXT = 4'b0001,
      MODE_ESC  = 4'b0010,
      MODE_HEX1 = 4'b0100,
      MODE_HEX2 = 4'b1000
   } mode_type;

   localparam logic [ERR_W-1:0] ERR_NONE    = 3'd0;
   localparam logic [ERR_W-1:0] ERR_UNKNOWN = 3'd1;
   localparam logic [ERR_W-1:0] ERR_FEW     = 3'd2;
   localparam logic [ERR_W-1:0] ERR_NONHEX  = 3'd3;
   localparam logic [ERR_W-1:0] ERR_NULL    = 3'd4;

   localparam logic [CHAR_W-1:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [CHAR_W-1:0] CHAR_N         = 8'h6E;
   localparam logic [CHAR_W-1:0] CHAR_T         = 8'h74;
   localparam logic [CHAR_W-1:0] CHAR_QUOTE     = 8'h22;
   localparam logic [CHAR_W-1:0] CHAR_X         = 8'h78;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              out_valid;
      logic [ERR_W-1:0]  error_code;
      logic              out_last;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] nibble;
   } hex_type;

   function automatic hex_type hex_decode(input logic [CHAR_W-1:0] c);
      hex_type h;
      h.ok     = 1'b1;
      h.nibble = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.nibble = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         // a-f and A-F share the low bits: 1..6 maps to 10..15
         h.nibble = c[3:0] + 4'd9;
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

// ----- rtl/sed_decode.sv -----
// ---------------------------------------------------------------------------
// sed_decode
// escape state registers and the per-byte decode of one beat
// ---------------------------------------------------------------------------
`include "string_escape_decoder_unit_defines.svh"

module sed_decode (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      beat_valid,
   input  logic [sed_pkg::CHAR_W-1:0] in_char,
   input  logic                      in_last,
   output sed_pkg::result_type       result
);
   import sed_pkg::*;

   mode_type         mode_ff,   mode_in;
   logic [3:0]       nibble_ff, nibble_in;
   logic [ERR_W-1:0] error_ff,  error_in;
   hex_type          hex;

   assign hex = hex_decode(in_char);

   always_comb begin
      mode_in           = mode_ff;
      nibble_in         = nibble_ff;
      error_in          = error_ff;
      result.out_char   = '0;
      result.out_valid  = 1'b0;
      result.out_last   = in_last;
      if (error_ff == ERR_NONE) begin
         case (mode_ff)
            MODE_TEXT: begin
               // a backslash on the final byte passes through literally
               if (in_char == CHAR_BACKSLASH && !in_last) begin
                  mode_in = MODE_ESC;
               end else begin
                  result.out_char  = in_char;
                  result.out_valid = 1'b1;
               end
            end
            MODE_ESC: begin
               mode_in = MODE_TEXT;
               if (in_char == CHAR_N) begin
                  result.out_char  = CHAR_NEWLINE;
                  result.out_valid = 1'b1;
               end else if (in_char == CHAR_T) begin
                  result.out_char  = CHAR_TAB;
                  result.out_valid = 1'b1;
               end else if (in_char == CHAR_QUOTE) begin
                  result.out_char  = CHAR_QUOTE;
                  result.out_valid = 1'b1;
               end else if (in_char == CHAR_X) begin
                  if (in_last) begin
                     error_in = ERR_FEW;
                  end else begin
                     mode_in = MODE_HEX1;
                  end
               end else begin
                  error_in = ERR_UNKNOWN;
               end
            end
            MODE_HEX1: begin
               mode_in = MODE_TEXT;
               // too few wins over non-hex
               if (in_last) begin
                  error_in = ERR_FEW;
               end else if (!hex.ok) begin
                  error_in = ERR_NONHEX;
               end else begin
                  nibble_in = hex.nibble;
                  mode_in   = MODE_HEX2;
               end
            end
            MODE_HEX2: begin
               mode_in = MODE_TEXT;
               if (!hex.ok) begin
                  error_in = ERR_NONHEX;
               end else if ({nibble_ff, hex.nibble} == 8'h00) begin
                  error_in = ERR_NULL;
               end else begin
                  result.out_char  = {nibble_ff, hex.nibble};
                  result.out_valid = 1'b1;
               end
            end
            default: begin
               mode_in = MODE_TEXT;
            end
         endcase
      end
      result.error_code = error_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (beat_valid && in_last)) begin
         mode_ff   <= MODE_TEXT;
         nibble_ff <= '0;
         error_ff  <= ERR_NONE;
      end else if (beat_valid) begin
         mode_ff   <= mode_in;
         nibble_ff <= nibble_in;
         error_ff  <= error_in;
      end
   end

   `SED_ASSERT_ALWAYS(a_err_blocks_byte, (result.error_code == ERR_NONE) || !result.out_valid, "byte emitted while error held")
   `SED_ASSERT_NEXT(a_last_clears, beat_valid && in_last, (mode_ff == MODE_TEXT) && (error_ff == ERR_NONE), "state not cleared after final byte")
   `SED_ASSERT_NEXT(a_err_sticky, beat_valid && !in_last && (error_ff != ERR_NONE), error_ff == $past(error_ff), "error changed inside a string")

endmodule

// ----- rtl/sed_out_buf.sv -----
// ---------------------------------------------------------------------------
// sed_out_buf
// result register with a skid stage so input and output stall independently
// ---------------------------------------------------------------------------
`include "string_escape_decoder_unit_defines.svh"

module sed_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  sed_pkg::result_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output sed_pkg::result_type out_data
);
   import sed_pkg::*;

   logic       out_valid_ff;
   logic       skid_valid_ff;
   result_type out_data_ff;
   result_type skid_data_ff;
   logic       push;
   logic       pop;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign push      = in_valid && !skid_valid_ff;
   assign pop       = out_valid_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         // output held: park the new beat in the skid stage
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
         end else if (push) begin
            out_data_ff <= in_data;
         end
      end else if (push) begin
         skid_data_ff <= in_data;
      end
   end

   `SED_ASSERT_ALWAYS(a_skid_needs_out, !skid_valid_ff || out_valid_ff, "skid full with output empty")
   `SED_ASSERT_NEXT(a_skid_fill, out_valid_ff && !out_ready && push, skid_valid_ff, "stalled beat not parked")
   `SED_ASSERT_NEXT(a_skid_drain, skid_valid_ff && out_ready, !skid_valid_ff && out_valid_ff, "skid did not drain")

endmodule

// ----- rtl/string_escape_decoder_unit.sv -----
// ---------------------------------------------------------------------------
// string_escape_decoder_unit
// streaming backslash escape decoder, one result beat per input byte
// ---------------------------------------------------------------------------
// a result is registered in the output register, or parked in the skid stage while the output is held
// throughput: one byte per cycle while the skid stage is empty; the escape state updates in the accept cycle
// a two-entry result buffer (output register plus skid) decouples the sides
// reset (synchronous, active high) returns to text mode with no error held
module string_escape_decoder_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [sed_pkg::CHAR_W-1:0] req_in_char,
   input  logic                       req_in_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [sed_pkg::CHAR_W-1:0] rsp_out_char,
   output logic                       rsp_out_valid,
   output logic [sed_pkg::ERR_W-1:0]  rsp_error_code,
   output logic                       rsp_out_last
);
   import sed_pkg::*;

   logic       beat_valid;
   result_type dec_result;
   result_type buf_result;

   assign beat_valid = req_valid && req_ready;

   sed_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (beat_valid),
      .in_char    (req_in_char),
      .in_last    (req_in_last),
      .result     (dec_result)
   );

   sed_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (dec_result),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (buf_result)
   );

   assign rsp_out_char   = buf_result.out_char;
   assign rsp_out_valid  = buf_result.out_valid;
   assign rsp_error_code = buf_result.error_code;
   assign rsp_out_last   = buf_result.out_last;

endmodule

// ----- bench/string_escape_decoder_unit_test.sv -----
// ---------------------------------------------------------------------------
// string_escape_decoder_unit_test
// escaped strings driven into the escape decoder one byte per beat, a
// behavioral decoder predicts each result beat and every returned beat is
// compared field by field in arrival order, with random idling on both sides
// and long receiver back-offs that fill the result buffer and stall the input
// ---------------------------------------------------------------------------
module string_escape_decoder_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sed_pkg::*;

   localparam logic [4:0] NIBBLE_BAD   = 5'd16;
   localparam int         RANDOM_BYTES = 1500;
   localparam int         LONG_HOLD    = 400;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } source_byte_type;

   typedef logic [CHAR_W-1:0] byte_list_type[$];

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [CHAR_W-1:0] req_in_char = '0;
   logic              req_in_last = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [CHAR_W-1:0] rsp_out_char;
   logic              rsp_out_valid;
   logic [ERR_W-1:0]  rsp_error_code;
   logic              rsp_out_last;

   source_byte_type source_bytes[$];
   result_type      expected_beats[$];

   // bench copy of the decoder state
   mode_type          dec_mode = MODE_TEXT;
   logic [3:0]        hi_nib   = '0;
   logic [ERR_W-1:0]  held_err = ERR_NONE;

   logic offering   = 1'b0;
   int   send_wait  = 0;
   int   recv_wait  = 0;
   int   hold_left  = 0;
   int   bytes_sent = 0;
   int   beats_seen = 0;
   int   mismatch_count = 0;

   string_escape_decoder_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_char    (req_in_char),
      .req_in_last    (req_in_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_out_valid  (rsp_out_valid),
      .rsp_error_code (rsp_error_code),
      .rsp_out_last   (rsp_out_last)
   );

   always #5 clock = ~clock;

   function automatic logic [4:0] nibble_of(input logic [CHAR_W-1:0] c);
      if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
      if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
      if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
      return NIBBLE_BAD;
   endfunction

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] n, input logic upper);
      if (n < 4'd10) return "0" + CHAR_W'(n);
      return (upper ? "A" : "a") + CHAR_W'(n) - 8'd10;
   endfunction

   function automatic logic [CHAR_W-1:0] pick_nonhex();
      logic [CHAR_W-1:0] c;
      do c = CHAR_W'($urandom()); while (nibble_of(c) != NIBBLE_BAD);
      return c;
   endfunction

   // runs one byte through the bench decoder and returns its result beat
   function automatic result_type decode_byte(input logic [CHAR_W-1:0] c, input logic last);
      result_type r;
      logic [4:0] h;
      r = '0;
      r.out_last = last;
      if (held_err == ERR_NONE) begin
         case (dec_mode)
            MODE_TEXT: begin
               if (c == CHAR_BACKSLASH && !last) begin
                  dec_mode = MODE_ESC;
               end else begin
                  r.out_char  = c;
                  r.out_valid = 1'b1;
               end
            end
            MODE_ESC: begin
               dec_mode = MODE_TEXT;
               if (c == CHAR_N) begin
                  r.out_char  = CHAR_NEWLINE;
                  r.out_valid = 1'b1;
               end else if (c == CHAR_T) begin
                  r.out_char  = CHAR_TAB;
                  r.out_valid = 1'b1;
               end else if (c == CHAR_QUOTE) begin
                  r.out_char  = CHAR_QUOTE;
                  r.out_valid = 1'b1;
               end else if (c == CHAR_X) begin
                  if (last) held_err = ERR_FEW;
                  else dec_mode = MODE_HEX1;
               end else begin
                  held_err = ERR_UNKNOWN;
               end
            end
            MODE_HEX1: begin
               h = nibble_of(c);
               dec_mode = MODE_TEXT;
               // running out of bytes outranks a bad digit
               if (last) begin
                  held_err = ERR_FEW;
               end else if (h == NIBBLE_BAD) begin
                  held_err = ERR_NONHEX;
               end else begin
                  hi_nib   = h[3:0];
                  dec_mode = MODE_HEX2;
               end
            end
            default: begin
               h = nibble_of(c);
               dec_mode = MODE_TEXT;
               if (h == NIBBLE_BAD) begin
                  held_err = ERR_NONHEX;
               end else if ({hi_nib, h[3:0]} == '0) begin
                  held_err = ERR_NULL;
               end else begin
                  r.out_char  = {hi_nib, h[3:0]};
                  r.out_valid = 1'b1;
               end
            end
         endcase
      end
      r.error_code = held_err;
      if (last) begin
         dec_mode = MODE_TEXT;
         hi_nib   = '0;
         held_err = ERR_NONE;
      end
      return r;
   endfunction

   // idle-free stretches alternate with random waits
   function automatic int draw_wait(input int idx);
      if ((idx / 150) % 3 == 1) return 0;
      return int'($urandom_range(0, 16));
   endfunction

   task automatic push_byte(input logic [CHAR_W-1:0] c, input logic last);
      source_byte_type b;
      b.ch   = c;
      b.last = last;
      source_bytes.push_back(b);
   endtask

   task automatic add_bytes(input byte_list_type s);
      foreach (s[i]) push_byte(s[i], i == s.size() - 1);
   endtask

   task automatic add_text(input string s);
      byte_list_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      add_bytes(q);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   // stimulus
   initial begin : fill_proc
      byte_list_type s;
      logic [3:0] hi, lo;
      logic [CHAR_W-1:0] c;
      int kind;
      int produced;

      // extremes of plain bytes, then every escape and a mixed-case hex pair
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      add_text("\\n\\t\\\"\\xfE");
      add_text("\\x00");       // decoded null
      add_text("\\\\");        // backslash after backslash
      add_text("\\x");         // string ends on the x
      add_text("\\xg");        // ends on the first digit, bad digit too
      add_text("\\xzq");       // bad first digit, sticky afterwards
      add_text("\\x4z");       // bad second digit on the final byte
      add_text("\\");          // lone backslash as the final byte

      produced = 0;
      while (produced < RANDOM_BYTES) begin
         s.delete();
         kind = $urandom_range(0, 9);
         if (kind < 2) begin
            // noise, heavy on backslashes
            repeat ($urandom_range(1, 10)) begin
               if ($urandom_range(0, 3) == 0) s.push_back(CHAR_BACKSLASH);
               else s.push_back(CHAR_W'($urandom()));
            end
         end else begin
            repeat ($urandom_range(1, 8)) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: begin
                     c = CHAR_W'($urandom());
                     if (c == CHAR_BACKSLASH) c = CHAR_W'($urandom_range(0, 91));
                     s.push_back(c);
                  end
                  4: begin s.push_back(CHAR_BACKSLASH); s.push_back(CHAR_N); end
                  5: begin s.push_back(CHAR_BACKSLASH); s.push_back(CHAR_T); end
                  6: begin s.push_back(CHAR_BACKSLASH); s.push_back(CHAR_QUOTE); end
                  7, 8: begin
                     hi = 4'($urandom());
                     lo = 4'($urandom());
                     if (hi == 0 && lo == 0 && $urandom_range(0, 3) != 0) lo = 4'd1;
                     s.push_back(CHAR_BACKSLASH);
                     s.push_back(CHAR_X);
                     s.push_back(hex_char(hi, 1'($urandom())));
                     s.push_back(hex_char(lo, 1'($urandom())));
                  end
                  default: begin
                     s.push_back(CHAR_BACKSLASH);
                     case ($urandom_range(0, 3))
                        0: begin
                           if ($urandom_range(0, 2) == 0) begin
                              c = CHAR_BACKSLASH;
                           end else begin
                              do c = CHAR_W'($urandom());
                              while (c == CHAR_N || c == CHAR_T ||
                                     c == CHAR_QUOTE || c == CHAR_X);
                           end
                           s.push_back(c);
                        end
                        1: begin
                           s.push_back(CHAR_X);
                           s.push_back(pick_nonhex());
                        end
                        2: begin
                           s.push_back(CHAR_X);
                           s.push_back(hex_char(4'($urandom()), 1'($urandom())));
                           s.push_back(pick_nonhex());
                        end
                        default: begin
                           s.push_back(CHAR_X);
                           s.push_back("0");
                           s.push_back("0");
                        end
                     endcase
                  end
               endcase
            end
            // cut some strings short, often in the middle of an escape
            if (kind == 2) begin
               repeat ($urandom_range(1, 2)) if (s.size() > 1) void'(s.pop_back());
            end
         end
         add_bytes(s);
         produced += s.size();
      end
   end

   initial begin : reset_proc
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // driver
   always @(posedge clock) begin : drive_proc
      source_byte_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         offering  = 1'b0;
         send_wait = 0;
         dec_mode  = MODE_TEXT;
         hi_nib    = '0;
         held_err  = ERR_NONE;
      end else begin
         if (req_valid && req_ready) begin
            expected_beats.push_back(decode_byte(req_in_char, req_in_last));
            bytes_sent++;
            offering  = 1'b0;
            send_wait = draw_wait(bytes_sent);
         end
         if (!offering) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (source_bytes.size() > 0) begin
               nxt = source_bytes.pop_front();
               req_in_char <= nxt.ch;
               req_in_last <= nxt.last;
               offering = 1'b1;
            end
         end
         req_valid <= offering;
      end
   end

   // monitor
   always @(posedge clock) begin : collect_proc
      result_type want;
      logic take;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait = 0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected beat, expected none actual %0h/%0h/%0h/%0h",
                        $time, rsp_out_char, rsp_out_valid, rsp_error_code, rsp_out_last);
            end else begin
               want = expected_beats.pop_front();
               check_field("out_char", want.out_char, rsp_out_char);
               check_field("out_valid", want.out_valid, rsp_out_valid);
               check_field("error_code", want.error_code, rsp_error_code);
               check_field("out_last", want.out_last, rsp_out_last);
            end
            beats_seen++;
            recv_wait = draw_wait(beats_seen);
            // long back-off so the result buffer fills and the input stalls
            if (beats_seen == 300 || beats_seen == 1100) hold_left = LONG_HOLD;
         end
         take = 1'b0;
         if (hold_left > 0) hold_left--;
         else if (recv_wait > 0) recv_wait--;
         else take = 1'b1;
         rsp_ready <= take;
      end
   end

   initial begin : finish_proc
      @(negedge clock);
      while (reset || source_bytes.size() > 0 || req_valid || expected_beats.size() > 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("string_escape_decoder_unit_test passed");
      end else begin
         $display("string_escape_decoder_unit_test failed");
      end
      $finish;
   end

   initial begin : timeout_proc
      #5_000_000;
      $display("string_escape_decoder_unit_test failed");
      $finish;
   end

endmodule
